// ----- hw/rtl/dcmf_pkg.sv -----
// ----------------------------------------------------------------------------
// dcmf_pkg: shared definitions for the dark channel minimum filter
// Sizes, register codes, payload types and the min helpers used by the
// line store and the top level.
// ----------------------------------------------------------------------------
package dcmf_pkg;

   // Store and window limits
   localparam int MAX_WIDTH  = 2048;
   localparam int MAX_RADIUS = 7;

   localparam int PIX_W = 8;
   typedef logic [PIX_W-1:0] pixel_type;
   localparam pixel_type PAD_VALUE = '1;

   // Configuration register widths and codes
   localparam int WIDTH_REG_W  = 12;
   localparam int HEIGHT_REG_W = 13;
   localparam int RADIUS_REG_W = 3;
   localparam int CSR_DATA_W   = 13;
   localparam int CSR_INDEX_W  = 2;

   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_WIDTH   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_HEIGHT  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_WINDOW_RADIUS = 2'd2;

   localparam logic [WIDTH_REG_W-1:0]  IMAGE_WIDTH_RESET   = 12'd640;
   localparam logic [HEIGHT_REG_W-1:0] IMAGE_HEIGHT_RESET  = 13'd480;
   localparam logic [RADIUS_REG_W-1:0] WINDOW_RADIUS_RESET = 3'd1;

   // Item codes
   localparam logic OPCODE_PIXEL = 1'b0;
   localparam logic OPCODE_FLUSH = 1'b1;

   // Derived sizes
   localparam int COL_W      = $clog2(MAX_WIDTH);
   localparam int POS_W      = $clog2(MAX_WIDTH + 1);
   localparam int ROW_W      = HEIGHT_REG_W + 1;
   localparam int RAD_W      = $clog2(MAX_RADIUS + 1);
   localparam int LANE_W     = $clog2(2 * MAX_RADIUS + 2);
   localparam int STORE_ROWS = 2 ** LANE_W;
   localparam int WIN_TAPS   = 2 * MAX_RADIUS + 1;
   localparam int LAG_W      = $clog2(MAX_RADIUS * MAX_WIDTH + MAX_RADIUS + 1);

   typedef logic [STORE_ROWS-1:0] lane_mask_type;
   typedef logic [WIN_TAPS-1:0] tap_mask_type;
   typedef pixel_type [STORE_ROWS-1:0] store_word_type;

   // One line store access: write of the new channel minimum and read of
   // the same column across all stored rows
   typedef struct packed {
      logic              wr_en;
      logic [COL_W-1:0]  col;
      logic [LANE_W-1:0] lane;
      pixel_type         value;
      lane_mask_type     row_mask;
   } line_req_type;

   function automatic pixel_type pixel_min(pixel_type a, pixel_type b);
      return (a < b) ? a : b;
   endfunction

   // Balanced min tree over one store word
   function automatic pixel_type tree_min(store_word_type vals);
      store_word_type level;
      level = vals;
      for (int l = 0; l < LANE_W; l++) begin
         for (int i = 0; i < (STORE_ROWS >> (l + 1)); i++) begin
            level[i] = pixel_min(level[2*i], level[2*i+1]);
         end
      end
      return level[0];
   endfunction

endpackage

// ----- hw/rtl/dcmf_req_if.sv -----
// ----------------------------------------------------------------------------
// dcmf_req_if: pixel input channel
// Valid/ready channel carrying one BGR pixel or flush item per beat.
// ----------------------------------------------------------------------------
interface dcmf_req_if;
   logic                valid;
   logic                ready;
   logic                opcode;
   dcmf_pkg::pixel_type blue;
   dcmf_pkg::pixel_type green;
   dcmf_pkg::pixel_type red;

   modport source (output valid, opcode, blue, green, red, input ready);
   modport sink (input valid, opcode, blue, green, red, output ready);
endinterface

// ----- hw/rtl/dcmf_rsp_if.sv -----
// ----------------------------------------------------------------------------
// dcmf_rsp_if: dark value output channel
// Valid/ready channel carrying one filtered pixel per beat.
// ----------------------------------------------------------------------------
interface dcmf_rsp_if;
   logic                valid;
   logic                ready;
   dcmf_pkg::pixel_type dark_value;
   logic                frame_end;

   modport source (output valid, dark_value, frame_end, input ready);
   modport sink (input valid, dark_value, frame_end, output ready);
endinterface

// ----- hw/rtl/dcmf_line_buf.sv -----
// ----------------------------------------------------------------------------
// dcmf_line_buf: line store and vertical minimum
// One word per column holds that column of every stored row. Each access
// writes at most one byte lane and reads the whole column; the registered word is
// reduced to the minimum over the rows inside the window.
// ----------------------------------------------------------------------------
module dcmf_line_buf (
   input  logic                   clock,
   input  logic                   access_en,
   input  dcmf_pkg::line_req_type line_req,
   output dcmf_pkg::pixel_type    col_min
);

   dcmf_pkg::store_word_type          line_mem [dcmf_pkg::MAX_WIDTH];

   dcmf_pkg::store_word_type          rd_word_ff;
   dcmf_pkg::pixel_type               value_ff;
   logic [dcmf_pkg::LANE_W-1:0]       lane_ff;
   dcmf_pkg::lane_mask_type           mask_ff;
   dcmf_pkg::store_word_type          masked_word;

   // Write the new byte lane; read the old column word
   always_ff @(posedge clock) begin
      if (access_en) begin
         if (line_req.wr_en) begin
            line_mem[line_req.col][line_req.lane] <= line_req.value;
         end
         rd_word_ff <= line_mem[line_req.col];
      end
   end

   always_ff @(posedge clock) begin
      if (access_en) begin
         value_ff <= line_req.value;
         lane_ff  <= line_req.lane;
         mask_ff  <= line_req.row_mask;
      end
   end

   // Forward the byte written in the same access; pad rows off the image
   always_comb begin
      for (int l = 0; l < dcmf_pkg::STORE_ROWS; l++) begin
         if (!mask_ff[l]) begin
            masked_word[l] = dcmf_pkg::PAD_VALUE;
         end else if (dcmf_pkg::LANE_W'(l) == lane_ff) begin
            masked_word[l] = value_ff;
         end else begin
            masked_word[l] = rd_word_ff[l];
         end
      end
      col_min = dcmf_pkg::tree_min(masked_word);
   end

endmodule

// ----- hw/rtl/dark_channel_min_filter.sv -----
// ----------------------------------------------------------------------------
// dark_channel_min_filter: dark channel minimum filter
// Min of B, G, R per pixel, then the minimum over a centered square window
// of configurable radius; positions outside the image count as 255.
//
//   channel  dir  beat payload                      handshake
//   req_chan in   opcode, blue, green, red          valid/ready
//   rsp_chan out  dark_value, frame_end             valid/ready
//   csr_*    in   csr_index, csr_wdata              csr_write_en
//
// Rate: one beat per clock sustained while the output is not stalled; the beat
// that completes a window passes through the line store stage and the window
// stage into the output register, from which its result can leave.
// The single line store port sets the rate: each beat reads one column of
// all stored rows and writes at most one byte of it in the same cycle.
// Reset clears counters, pipeline valids and registers to their defaults;
// the line store is not cleared, rows are only read after being written.
// A stalled result holds in the output register while earlier stages
// keep taking beats until all of them are full.
// ----------------------------------------------------------------------------
module dark_channel_min_filter (
   input  logic                                clock,
   input  logic                                reset,
   dcmf_req_if.sink                            req_chan,
   dcmf_rsp_if.source                          rsp_chan,
   input  logic                                csr_write_en,
   input  logic [dcmf_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [dcmf_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   // Configuration
   logic [dcmf_pkg::WIDTH_REG_W-1:0]  width_ff;
   logic [dcmf_pkg::HEIGHT_REG_W-1:0] height_ff;
   logic [dcmf_pkg::RADIUS_REG_W-1:0] radius_ff;

   logic [dcmf_pkg::POS_W-1:0]        w_eff;
   logic [dcmf_pkg::HEIGHT_REG_W-1:0] h_eff;
   logic [dcmf_pkg::RAD_W-1:0]        r_eff;
   logic [dcmf_pkg::LAG_W-1:0]        lag;

   // Position counters
   logic [dcmf_pkg::COL_W-1:0]        in_col_ff, in_col_in;
   logic [dcmf_pkg::ROW_W-1:0]        in_row_ff, in_row_in;
   logic [dcmf_pkg::COL_W-1:0]        out_col_ff, out_col_in;
   logic [dcmf_pkg::HEIGHT_REG_W-1:0] out_row_ff, out_row_in;
   logic [dcmf_pkg::LAG_W-1:0]        lag_cnt_ff, lag_cnt_in;

   // Stage 0 decode
   logic                              req_accept;
   logic                              emit;
   logic                              last;
   logic                              in_wrap;
   logic                              out_wrap;
   dcmf_pkg::pixel_type               chan_min;
   dcmf_pkg::line_req_type            line_req;
   dcmf_pkg::tap_mask_type            tap_mask;

   // Stage 1: line store read
   logic                              s1_valid_ff;
   logic                              s1_emit_ff;
   logic                              s1_last_ff;
   dcmf_pkg::tap_mask_type            s1_taps_ff;
   dcmf_pkg::pixel_type               col_min;

   // Stage 2: column minimum window
   logic                              s2_valid_ff;
   logic                              s2_emit_ff;
   logic                              s2_last_ff;
   dcmf_pkg::tap_mask_type            s2_taps_ff;
   dcmf_pkg::pixel_type               window_ff [dcmf_pkg::WIN_TAPS];
   dcmf_pkg::store_word_type          tap_word;
   dcmf_pkg::pixel_type               dark_min;

   // Output register
   logic                              rsp_valid_ff;
   dcmf_pkg::pixel_type               rsp_dark_ff;
   logic                              rsp_last_ff;

   // Flow control
   logic                              out_adv;
   logic                              s2_free;
   logic                              s1_free;

   // -------------------------------------------------------------------------
   // Configuration registers; any write restarts the frame
   // -------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= dcmf_pkg::IMAGE_WIDTH_RESET;
         height_ff <= dcmf_pkg::IMAGE_HEIGHT_RESET;
         radius_ff <= dcmf_pkg::WINDOW_RADIUS_RESET;
      end else if (csr_write_en) begin
         case (csr_index)
            dcmf_pkg::CSR_IMAGE_WIDTH: begin
               width_ff <= csr_wdata[dcmf_pkg::WIDTH_REG_W-1:0];
            end
            dcmf_pkg::CSR_IMAGE_HEIGHT: begin
               height_ff <= csr_wdata[dcmf_pkg::HEIGHT_REG_W-1:0];
            end
            dcmf_pkg::CSR_WINDOW_RADIUS: begin
               radius_ff <= csr_wdata[dcmf_pkg::RADIUS_REG_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // Clamp the registers to the supported ranges
   always_comb begin
      if (width_ff == '0) begin
         w_eff = dcmf_pkg::POS_W'(1);
      end else if (dcmf_pkg::POS_W'(width_ff) > dcmf_pkg::POS_W'(dcmf_pkg::MAX_WIDTH)) begin
         w_eff = dcmf_pkg::POS_W'(dcmf_pkg::MAX_WIDTH);
      end else begin
         w_eff = dcmf_pkg::POS_W'(width_ff);
      end

      h_eff = (height_ff == '0) ? dcmf_pkg::HEIGHT_REG_W'(1) : height_ff;

      if (radius_ff == '0) begin
         r_eff = dcmf_pkg::RAD_W'(1);
      end else if (dcmf_pkg::RAD_W'(radius_ff) > dcmf_pkg::RAD_W'(dcmf_pkg::MAX_RADIUS)) begin
         r_eff = dcmf_pkg::RAD_W'(dcmf_pkg::MAX_RADIUS);
      end else begin
         r_eff = dcmf_pkg::RAD_W'(radius_ff);
      end

      // Beats before the first result: radius rows plus radius pixels
      lag = dcmf_pkg::LAG_W'(r_eff) * dcmf_pkg::LAG_W'(w_eff) + dcmf_pkg::LAG_W'(r_eff);
   end

   // -------------------------------------------------------------------------
   // Flow control: each stage advances when the one after it has room
   // -------------------------------------------------------------------------
   assign out_adv    = !rsp_valid_ff || rsp_chan.ready;
   assign s2_free    = !s2_valid_ff || !s2_emit_ff || out_adv;
   assign s1_free    = !s1_valid_ff || s2_free;
   assign req_accept = req_chan.valid && s1_free;

   assign req_chan.ready = s1_free;

   // -------------------------------------------------------------------------
   // Stage 0: counters, channel minimum and window masks
   // -------------------------------------------------------------------------
   assign emit     = (lag_cnt_ff == lag);
   assign in_wrap  = (dcmf_pkg::POS_W'(in_col_ff) + dcmf_pkg::POS_W'(1)) >= w_eff;
   assign out_wrap = (dcmf_pkg::POS_W'(out_col_ff) + dcmf_pkg::POS_W'(1)) >= w_eff;
   assign last     = emit && (out_row_ff == h_eff - dcmf_pkg::HEIGHT_REG_W'(1))
                     && (dcmf_pkg::POS_W'(out_col_ff) == w_eff - dcmf_pkg::POS_W'(1));

   always_comb begin
      in_col_in  = in_col_ff;
      in_row_in  = in_row_ff;
      out_col_in = out_col_ff;
      out_row_in = out_row_ff;
      lag_cnt_in = lag_cnt_ff;

      if (req_accept) begin
         if (in_wrap) begin
            in_col_in = '0;
            in_row_in = in_row_ff + dcmf_pkg::ROW_W'(1);
         end else begin
            in_col_in = in_col_ff + dcmf_pkg::COL_W'(1);
         end

         if (!emit) begin
            lag_cnt_in = lag_cnt_ff + dcmf_pkg::LAG_W'(1);
         end else if (last) begin
            // Frame done: the next beat starts a new frame
            in_col_in  = '0;
            in_row_in  = '0;
            out_col_in = '0;
            out_row_in = '0;
            lag_cnt_in = '0;
         end else if (out_wrap) begin
            out_col_in = '0;
            out_row_in = out_row_ff + dcmf_pkg::HEIGHT_REG_W'(1);
         end else begin
            out_col_in = out_col_ff + dcmf_pkg::COL_W'(1);
         end
      end

      if (csr_write_en) begin
         in_col_in  = '0;
         in_row_in  = '0;
         out_col_in = '0;
         out_row_in = '0;
         lag_cnt_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_col_ff  <= '0;
         in_row_ff  <= '0;
         out_col_ff <= '0;
         out_row_ff <= '0;
         lag_cnt_ff <= '0;
      end else begin
         in_col_ff  <= in_col_in;
         in_row_ff  <= in_row_in;
         out_col_ff <= out_col_in;
         out_row_ff <= out_row_in;
         lag_cnt_ff <= lag_cnt_in;
      end
   end

   // Channel minimum; flush beats store padding
   assign chan_min = dcmf_pkg::pixel_min(dcmf_pkg::pixel_min(req_chan.blue, req_chan.green),
                                         req_chan.red);

   // Row mask: the lane at distance d above the input row is in the window
   // when d is at most twice the radius and the row lies inside the image.
   // Column taps: tap j is the column min of the beat j back, which sits
   // radius-j columns right of the output center; drop those off the row.
   always_comb begin
      logic [dcmf_pkg::LANE_W-1:0] row_dist;
      logic [dcmf_pkg::LANE_W:0]   span;
      logic [dcmf_pkg::POS_W-1:0]  tap_pos;

      span    = (dcmf_pkg::LANE_W+1)'({r_eff, 1'b0});
      tap_pos = dcmf_pkg::POS_W'(out_col_ff) + dcmf_pkg::POS_W'(r_eff);

      line_req.wr_en = in_row_ff < dcmf_pkg::ROW_W'(h_eff);
      line_req.col   = in_col_ff;
      line_req.lane  = in_row_ff[dcmf_pkg::LANE_W-1:0];
      line_req.value = (req_chan.opcode == dcmf_pkg::OPCODE_FLUSH) ? dcmf_pkg::PAD_VALUE
                                                                   : chan_min;

      for (int l = 0; l < dcmf_pkg::STORE_ROWS; l++) begin
         row_dist = in_row_ff[dcmf_pkg::LANE_W-1:0] - dcmf_pkg::LANE_W'(l);
         line_req.row_mask[l] = ({1'b0, row_dist} <= span)
            && (dcmf_pkg::ROW_W'(row_dist) <= in_row_ff)
            && ((in_row_ff - dcmf_pkg::ROW_W'(row_dist)) < dcmf_pkg::ROW_W'(h_eff));
      end

      for (int j = 0; j < dcmf_pkg::WIN_TAPS; j++) begin
         tap_mask[j] = (dcmf_pkg::POS_W'(j) <= dcmf_pkg::POS_W'(span))
            && (dcmf_pkg::POS_W'(j) <= tap_pos)
            && ((tap_pos - dcmf_pkg::POS_W'(j)) < w_eff);
      end
   end

   // -------------------------------------------------------------------------
   // Stage 1: line store access and column minimum
   // -------------------------------------------------------------------------
   dcmf_line_buf u_line_buf (
      .clock     (clock),
      .access_en (req_accept),
      .line_req  (line_req),
      .col_min   (col_min)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_free) begin
         s1_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_emit_ff <= emit;
         s1_last_ff <= last;
         s1_taps_ff <= tap_mask;
      end
   end

   // -------------------------------------------------------------------------
   // Stage 2: shift the column minimum into the window, one tap per beat
   // -------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
         s2_emit_ff  <= 1'b0;
         for (int j = 0; j < dcmf_pkg::WIN_TAPS; j++) begin
            window_ff[j] <= dcmf_pkg::PAD_VALUE;
         end
      end else if (s2_free) begin
         s2_valid_ff <= s1_valid_ff;
         if (s1_valid_ff) begin
            s2_emit_ff   <= s1_emit_ff;
            window_ff[0] <= col_min;
            for (int j = 1; j < dcmf_pkg::WIN_TAPS; j++) begin
               window_ff[j] <= window_ff[j-1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s2_free && s1_valid_ff) begin
         s2_last_ff <= s1_last_ff;
         s2_taps_ff <= s1_taps_ff;
      end
   end

   // Horizontal minimum over the taps that land on the image row
   always_comb begin
      tap_word = '1;
      for (int j = 0; j < dcmf_pkg::WIN_TAPS; j++) begin
         tap_word[j] = s2_taps_ff[j] ? window_ff[j] : dcmf_pkg::PAD_VALUE;
      end
      dark_min = dcmf_pkg::tree_min(tap_word);
   end

   // -------------------------------------------------------------------------
   // Output register; hold while the sink stalls
   // -------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_adv) begin
         rsp_valid_ff <= s2_valid_ff && s2_emit_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (out_adv && s2_valid_ff && s2_emit_ff) begin
         rsp_dark_ff <= dark_min;
         rsp_last_ff <= s2_last_ff;
      end
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.dark_value = rsp_dark_ff;
   assign rsp_chan.frame_end  = rsp_last_ff;

endmodule

// ----- hw/rtl/dcmf_checker.sv -----
// ----------------------------------------------------------------------------
// dcmf_checker: port checks for the dark channel minimum filter
// Watches the channel handshakes of the top level over time.
// ----------------------------------------------------------------------------
module dcmf_checker (
   input logic                clock,
   input logic                reset,
   input logic                req_ready,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input dcmf_pkg::pixel_type rsp_dark_value,
   input logic                rsp_frame_end
);

   // A stalled result beat holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_dark_value)
                                  && $stable(rsp_frame_end))
      else $error("result beat changed while stalled");

   // With the output free the pipeline must take input
   a_ready_drained: assert property (@(posedge clock) disable iff (reset)
      (!rsp_valid || rsp_ready) |-> req_ready)
      else $error("input stalled while output side free");

   // Reset drops any pending result
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // A result never shows on the first cycle out of reset
   a_no_rsp_without_history: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !$past(reset))
      else $error("result appeared straight out of reset");

endmodule

bind dark_channel_min_filter dcmf_checker u_dcmf_checker (
   .clock          (clock),
   .reset          (reset),
   .req_ready      (req_chan.ready),
   .rsp_valid      (rsp_chan.valid),
   .rsp_ready      (rsp_chan.ready),
   .rsp_dark_value (rsp_chan.dark_value),
   .rsp_frame_end  (rsp_chan.frame_end)
);

// ----- tb/sv/dark_channel_min_filter_tb.sv -----
// ----------------------------------------------------------------------------
// dark_channel_min_filter_tb: self-checking bench for the dark channel filter
// Drives raster-order BGR pixels and flush beats into the filter under random
// idling on both channels. A local pixel-exact model tracks the line store and
// the input and output positions, and predicts every dark value and frame end.
// Covers reset geometry, channel extremes, clamped sizes, deep windows,
// restarts by register writes and random frames, both full and cut short.
// ----------------------------------------------------------------------------
module dark_channel_min_filter_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CLOCK_HALF    = 6;
   localparam int RESET_CYCLES  = 8;
   // Output register sits behind the line store and window stages; allow margin
   localparam int SETTLE_CYCLES = 16;
   localparam int MAX_SHOWN     = 10;
   localparam int BASE_IDLE_PCT = 18;
   localparam int RANDOM_ITEMS  = 80;
   // Rows the model keeps: one full window plus one row being filled
   localparam int STORE_DEPTH   = 2 * dcmf_pkg::MAX_RADIUS + 2;
   // Index past the register list: changes nothing but restarts the frame
   localparam logic [dcmf_pkg::CSR_INDEX_W-1:0] CSR_SPARE = 2'd3;

   typedef struct {
      dcmf_pkg::pixel_type dark_value;
      logic                frame_end;
   } dark_result_type;

   logic                             clock = 1'b0;
   logic                             reset;
   logic                             csr_write_en;
   logic [dcmf_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [dcmf_pkg::CSR_DATA_W-1:0]  csr_wdata;

   dcmf_req_if req_chan ();
   dcmf_rsp_if rsp_chan ();

   dark_channel_min_filter dut (
      .clock        (clock),
      .reset        (reset),
      .req_chan     (req_chan),
      .rsp_chan     (rsp_chan),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   always #CLOCK_HALF clock = ~clock;

   // -------------------------------------------------------------------------
   // Model state: raw register copies, channel-minimum store, positions
   // -------------------------------------------------------------------------
   logic [dcmf_pkg::WIDTH_REG_W-1:0]  reg_width;
   logic [dcmf_pkg::HEIGHT_REG_W-1:0] reg_height;
   logic [dcmf_pkg::RADIUS_REG_W-1:0] reg_radius;
   dcmf_pkg::pixel_type               min_store [STORE_DEPTH][dcmf_pkg::MAX_WIDTH];
   int                                in_row, in_col, out_row, out_col;

   dark_result_type dark_due [$];
   int              mismatch_count = 0;
   int              items_sent = 0;
   int              idle_pct = BASE_IDLE_PCT;

   function automatic void clear_positions();
      in_row  = 0;
      in_col  = 0;
      out_row = 0;
      out_col = 0;
   endfunction

   // Effective geometry: zero sizes act as one, oversize values saturate
   function automatic void frame_geometry(output int w, output int h, output int rad);
      w   = (reg_width == 0) ? 1 :
            ((reg_width > dcmf_pkg::MAX_WIDTH) ? dcmf_pkg::MAX_WIDTH : int'(reg_width));
      h   = (reg_height == 0) ? 1 : int'(reg_height);
      rad = (reg_radius == 0) ? 1 :
            ((reg_radius > dcmf_pkg::MAX_RADIUS) ? dcmf_pkg::MAX_RADIUS : int'(reg_radius));
   endfunction

   // Advance the model by one accepted beat; queue the dark value it releases
   function automatic void predict_beat(logic opcode, dcmf_pkg::pixel_type blue,
                                        dcmf_pkg::pixel_type green,
                                        dcmf_pkg::pixel_type red);
      int                  w, h, rad, lag, pos, r, c;
      dcmf_pkg::pixel_type v;
      dcmf_pkg::pixel_type best;
      dark_result_type     res;
      frame_geometry(w, h, rad);
      lag = rad * w + rad;
      if (opcode == dcmf_pkg::OPCODE_FLUSH) begin
         v = dcmf_pkg::PAD_VALUE;
      end else begin
         v = blue;
         if (green < v) v = green;
         if (red < v) v = red;
      end
      if (in_row < h && in_col < w) min_store[in_row % STORE_DEPTH][in_col] = v;
      pos = in_row * w + in_col;
      in_col++;
      if (in_col >= w) begin
         in_col = 0;
         in_row++;
      end
      if (pos < lag || out_row >= h) return;
      // Window minimum, outside positions count as padding
      best = dcmf_pkg::PAD_VALUE;
      for (r = out_row - rad; r <= out_row + rad; r++) begin
         if (r >= 0 && r < h) begin
            for (c = out_col - rad; c <= out_col + rad; c++) begin
               if (c >= 0 && c < w) begin
                  if (min_store[r % STORE_DEPTH][c] < best) best = min_store[r % STORE_DEPTH][c];
               end
            end
         end
      end
      res.dark_value = best;
      res.frame_end  = (out_row == h - 1) && (out_col == w - 1);
      dark_due.push_back(res);
      if (res.frame_end) begin
         clear_positions();
      end else begin
         out_col++;
         if (out_col >= w) begin
            out_col = 0;
            out_row++;
         end
      end
   endfunction

   function automatic void note_mismatch(string msg);
      mismatch_count++;
      if (mismatch_count <= MAX_SHOWN) $display("[%0t] mismatch: %s", $realtime, msg);
   endfunction

   // Bias channels toward the extremes so the min path sees 0 and 255 often
   function automatic dcmf_pkg::pixel_type random_channel();
      case ($urandom_range(7))
         0: return '0;
         1: return dcmf_pkg::PAD_VALUE;
         default: return dcmf_pkg::pixel_type'($urandom_range(255));
      endcase
   endfunction

   // -------------------------------------------------------------------------
   // Result side: random backpressure and in-order compare
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      rsp_chan.ready <= ($urandom_range(99) >= idle_pct);
   end

   always @(posedge clock) begin
      dark_result_type want;
      if (!reset && rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1) begin
         if (dark_due.size() == 0) begin
            note_mismatch($sformatf("unexpected beat dark_value=%0d frame_end=%0b",
                                    rsp_chan.dark_value, rsp_chan.frame_end));
         end else begin
            want = dark_due.pop_front();
            if (rsp_chan.dark_value !== want.dark_value)
               note_mismatch($sformatf("dark_value expected %0d got %0d",
                                       want.dark_value, rsp_chan.dark_value));
            if (rsp_chan.frame_end !== want.frame_end)
               note_mismatch($sformatf("frame_end expected %0b got %0b",
                                       want.frame_end, rsp_chan.frame_end));
         end
      end
   end

   // -------------------------------------------------------------------------
   // Sender side
   // -------------------------------------------------------------------------

   // Send one beat; valid stays high on return so back-to-back beats never
   // drop and re-raise it within one step
   task automatic send_beat(input logic opcode, input dcmf_pkg::pixel_type blue,
                            input dcmf_pkg::pixel_type green,
                            input dcmf_pkg::pixel_type red);
      while ($urandom_range(99) < idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid  <= 1'b1;
      req_chan.opcode <= opcode;
      req_chan.blue   <= blue;
      req_chan.green  <= green;
      req_chan.red    <= red;
      do @(posedge clock); while (req_chan.ready !== 1'b1);
      predict_beat(opcode, blue, green, red);
      items_sent++;
   endtask

   // Send beats first..last-1 of a frame under the current geometry: image
   // pixels (some replaced by flush beats) followed by trailing beats, mostly flush
   task automatic send_span(input int first, input int last);
      int w, h, rad, i;
      frame_geometry(w, h, rad);
      for (i = first; i < last; i++) begin
         if (i < h * w)
            send_beat(($urandom_range(9) == 0) ? dcmf_pkg::OPCODE_FLUSH : dcmf_pkg::OPCODE_PIXEL,
                      random_channel(), random_channel(), random_channel());
         else
            send_beat(($urandom_range(9) == 0) ? dcmf_pkg::OPCODE_PIXEL : dcmf_pkg::OPCODE_FLUSH,
                      random_channel(), random_channel(), random_channel());
      end
   endtask

   function automatic int frame_beats();
      int w, h, rad;
      frame_geometry(w, h, rad);
      return h * w + rad * w + rad;
   endfunction

   // Hold the sender until every expected result is out, then let the
   // pipeline settle so no beat is left in flight
   task automatic wait_idle();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (dark_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // One register write beat; the caller drops the enable afterwards
   task automatic write_csr(input logic [dcmf_pkg::CSR_INDEX_W-1:0] idx,
                            input logic [dcmf_pkg::CSR_DATA_W-1:0] data);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= data;
      @(posedge clock);
      case (idx)
         dcmf_pkg::CSR_IMAGE_WIDTH:   reg_width  = data[dcmf_pkg::WIDTH_REG_W-1:0];
         dcmf_pkg::CSR_IMAGE_HEIGHT:  reg_height = data[dcmf_pkg::HEIGHT_REG_W-1:0];
         dcmf_pkg::CSR_WINDOW_RADIUS: reg_radius = data[dcmf_pkg::RADIUS_REG_W-1:0];
         default: ;
      endcase
      clear_positions();
   endtask

   // Program all three registers; unused upper data bits are randomized
   task automatic program_regs(input logic [dcmf_pkg::WIDTH_REG_W-1:0] w,
                               input logic [dcmf_pkg::HEIGHT_REG_W-1:0] h,
                               input logic [dcmf_pkg::RADIUS_REG_W-1:0] rad);
      wait_idle();
      write_csr(dcmf_pkg::CSR_IMAGE_WIDTH, {1'($urandom_range(1)), w});
      write_csr(dcmf_pkg::CSR_IMAGE_HEIGHT, h);
      write_csr(dcmf_pkg::CSR_WINDOW_RADIUS, {10'($urandom), rad});
      csr_write_en <= 1'b0;
   endtask

   task automatic restart_frame();
      wait_idle();
      write_csr(CSR_SPARE, dcmf_pkg::CSR_DATA_W'($urandom));
      csr_write_en <= 1'b0;
   endtask

   // -------------------------------------------------------------------------
   // Tests
   // -------------------------------------------------------------------------

   // Reset geometry is 640 wide with radius 1: the first 641 beats give
   // nothing. Send a short quiet start, then restart the frame with a write
   // to an unused index.
   task automatic test_reset_defaults();
      send_span(0, 40);
      restart_frame();
   endtask

   // Small frame whose pixels hit every channel extreme and a flush inside
   // the image
   task automatic test_field_extremes();
      int                  i;
      dcmf_pkg::pixel_type b, g, r;
      logic                op;
      program_regs(5, 5, 1);
      for (i = 0; i < 31; i++) begin
         op = dcmf_pkg::OPCODE_PIXEL;
         b  = dcmf_pkg::pixel_type'($urandom_range(255));
         g  = dcmf_pkg::pixel_type'($urandom_range(255));
         r  = dcmf_pkg::pixel_type'($urandom_range(255));
         case (i)
            0: begin b = '0; g = '0; r = '0; end
            1: begin
               b = dcmf_pkg::PAD_VALUE; g = dcmf_pkg::PAD_VALUE; r = dcmf_pkg::PAD_VALUE;
            end
            2: begin b = '0; g = dcmf_pkg::PAD_VALUE; r = dcmf_pkg::PAD_VALUE; end
            3: begin b = dcmf_pkg::PAD_VALUE; g = '0; r = dcmf_pkg::PAD_VALUE; end
            4: begin b = dcmf_pkg::PAD_VALUE; g = dcmf_pkg::PAD_VALUE; r = '0; end
            5: begin op = dcmf_pkg::OPCODE_FLUSH; b = '0; g = '0; r = '0; end
            12: begin b = 8'h55; g = 8'hAA; r = 8'h5A; end
            13: begin b = 8'hAA; g = 8'h55; r = 8'hA5; end
            default: ;
         endcase
         if (i >= 25) op = dcmf_pkg::OPCODE_FLUSH;
         send_beat(op, b, g, r);
      end
   endtask

   // Zero and oversize register values: width, height and radius clamps.
   // The oversize width and the tallest height only get the start of a
   // frame; the tall one still runs many rows past the store depth.
   task automatic test_size_clamps();
      program_regs(0, 4, 2);
      send_span(0, frame_beats());
      program_regs(7, 0, 0);
      send_span(0, frame_beats());
      program_regs(1, 1, 7);
      send_span(0, frame_beats());
      program_regs(12'd4095, 1, 1);
      send_span(0, 20);
      program_regs(1, 13'd8191, 1);
      send_span(0, 30);
   endtask

   // Largest window over more rows than the store holds, two frames back
   // to back with no rewrite in between and no idling on either side
   task automatic test_deep_window();
      program_regs(3, 18, 7);
      idle_pct = 0;
      repeat (2) send_span(0, frame_beats());
      idle_pct = BASE_IDLE_PCT;
   endtask

   // Random geometry and content: mostly whole frames, some paused midway
   // until the results drain, some cut short
   task automatic test_random_frames();
      int goal, total, cut;
      goal = items_sent + RANDOM_ITEMS;
      while (items_sent < goal) begin
         program_regs(dcmf_pkg::WIDTH_REG_W'($urandom_range(12)),
                      dcmf_pkg::HEIGHT_REG_W'($urandom_range(9)),
                      dcmf_pkg::RADIUS_REG_W'($urandom_range(7)));
         repeat (($urandom_range(3) == 0) ? 2 : 1) begin
            total = frame_beats();
            cut   = $urandom_range(total - 1, 1);
            case ($urandom_range(5))
               0: send_span(0, cut);
               1: begin
                  send_span(0, cut);
                  wait_idle();
                  send_span(cut, total);
               end
               default: send_span(0, total);
            endcase
         end
      end
   endtask

   // -------------------------------------------------------------------------
   // Main sequence
   // -------------------------------------------------------------------------
   initial begin
      reset           <= 1'b1;
      csr_write_en    <= 1'b0;
      csr_index       <= dcmf_pkg::CSR_IMAGE_WIDTH;
      csr_wdata       <= '0;
      req_chan.valid  <= 1'b0;
      req_chan.opcode <= dcmf_pkg::OPCODE_PIXEL;
      req_chan.blue   <= '0;
      req_chan.green  <= '0;
      req_chan.red    <= '0;
      reg_width  = dcmf_pkg::IMAGE_WIDTH_RESET;
      reg_height = dcmf_pkg::IMAGE_HEIGHT_RESET;
      reg_radius = dcmf_pkg::WINDOW_RADIUS_RESET;
      foreach (min_store[i, j]) min_store[i][j] = dcmf_pkg::PAD_VALUE;
      clear_positions();
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_defaults();
      test_field_extremes();
      test_size_clamps();
      test_deep_window();
      test_random_frames();

      // Drain and give the pipeline time to show any stray beat
      wait_idle();
      if (mismatch_count == 0) begin
         $display("dark_channel_min_filter test passed");
      end else begin
         $display("dark_channel_min_filter test failed");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest legal run
   initial begin
      #10ms;
      $display("dark_channel_min_filter test failed");
      $finish;
   end

endmodule

// ----- filelist.f -----
hw/rtl/dcmf_pkg.sv
hw/rtl/dcmf_req_if.sv
hw/rtl/dcmf_rsp_if.sv
hw/rtl/dcmf_line_buf.sv
hw/rtl/dark_channel_min_filter.sv
hw/rtl/dcmf_checker.sv
tb/sv/dark_channel_min_filter_tb.sv
